[hdl/smp_pkg.sv]
// ----------------------------------------------------------------------------
// smp_pkg
// Shared types and constants for the stun message parser.
// ----------------------------------------------------------------------------
package smp_pkg;

  localparam int unsigned HdrBytes = 20;
  localparam int unsigned HdrCntW  = 5;

  localparam logic [31:0] MagicCookie     = 32'h2112_A442;
  localparam logic [15:0] UserAttrCodeRst = 16'd6;

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_ATTR_HDR = 2'd1,
    PH_VALUE    = 2'd2,
    PH_PAD      = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_HDR_OK     = 2'd0,
    EV_BAD_COOKIE = 2'd1,
    EV_ATTR_START = 2'd2,
    EV_USER_BYTE  = 2'd3
  } evt_kind_t;

  typedef struct packed {
    evt_kind_t   kind;
    logic [15:0] msg_type;
    logic [15:0] msg_length;
    logic [31:0] txn_high;
    logic [31:0] txn_mid;
    logic [31:0] txn_low;
    logic [15:0] tlv_type;
    logic [15:0] tlv_length;
    logic [7:0]  value_byte;
    logic        last_value;
  } evt_t;

endpackage

[hdl/smp_parser.sv]
// ----------------------------------------------------------------------------
// smp_parser
// Byte-serial header assembly and attribute walk; at most one event per byte.
// ----------------------------------------------------------------------------
module smp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        data_byte,
  input  logic              chunk_end,
  input  logic [15:0]       user_code,
  output logic              evt_valid,
  output smp_pkg::evt_t     evt
);

  logic [smp_pkg::HdrCntW-1:0] hdr_cnt_r, hdr_cnt_nxt;
  smp_pkg::phase_t             phase_r, phase_nxt;
  logic [15:0]                 type_r, type_nxt;
  logic [15:0]                 len_r, len_nxt;
  logic [31:0]                 cookie_r, cookie_nxt;
  logic [31:0]                 txn_r [3];
  logic [31:0]                 txn_nxt [3];
  logic [1:0]                  ahdr_cnt_r, ahdr_cnt_nxt;
  logic [15:0]                 tlv_type_r, tlv_type_nxt;
  logic [15:0]                 val_left_r, val_left_nxt;
  logic [1:0]                  pad_left_r, pad_left_nxt;
  logic                        discard_r, discard_nxt;

  logic [1:0]                  txn_sel;

  always_comb begin
    hdr_cnt_nxt   = hdr_cnt_r;
    phase_nxt     = phase_r;
    type_nxt      = type_r;
    len_nxt       = len_r;
    cookie_nxt    = cookie_r;
    txn_nxt[0]    = txn_r[0];
    txn_nxt[1]    = txn_r[1];
    txn_nxt[2]    = txn_r[2];
    ahdr_cnt_nxt  = ahdr_cnt_r;
    tlv_type_nxt  = tlv_type_r;
    val_left_nxt  = val_left_r;
    pad_left_nxt  = pad_left_r;
    discard_nxt   = discard_r;
    evt_valid     = 1'b0;
    evt.kind      = smp_pkg::EV_HDR_OK;
    txn_sel       = 2'((hdr_cnt_r - 5'd8) >> 2);
    evt.tlv_type    = 16'd0;
    evt.tlv_length  = 16'd0;
    evt.value_byte  = 8'd0;
    evt.last_value  = 1'b0;

    if (byte_valid && !discard_r) begin
      case (phase_r)
        smp_pkg::PH_HEADER: begin
          if (hdr_cnt_r < 5'd2) begin
            type_nxt = {type_r[7:0], data_byte};
          end else if (hdr_cnt_r < 5'd4) begin
            len_nxt = {len_r[7:0], data_byte};
          end else if (hdr_cnt_r < 5'd8) begin
            cookie_nxt = {cookie_r[23:0], data_byte};
          end else if (hdr_cnt_r < 5'(smp_pkg::HdrBytes)) begin
            case (txn_sel)
              2'd0:    txn_nxt[0] = {txn_r[0][23:0], data_byte};
              2'd1:    txn_nxt[1] = {txn_r[1][23:0], data_byte};
              default: txn_nxt[2] = {txn_r[2][23:0], data_byte};
            endcase
          end
          if (hdr_cnt_r < 5'(smp_pkg::HdrBytes)) begin
            hdr_cnt_nxt = hdr_cnt_r + 5'd1;
          end
          if (hdr_cnt_nxt == 5'(smp_pkg::HdrBytes)) begin
            evt_valid = 1'b1;
            phase_nxt = smp_pkg::PH_ATTR_HDR;
            if (cookie_r == smp_pkg::MagicCookie) begin
              evt.kind     = smp_pkg::EV_HDR_OK;
              ahdr_cnt_nxt = 2'd0;
            end else begin
              evt.kind    = smp_pkg::EV_BAD_COOKIE;
              discard_nxt = 1'b1;
            end
          end
        end
        smp_pkg::PH_ATTR_HDR: begin
          if (ahdr_cnt_r < 2'd2) begin
            tlv_type_nxt = {tlv_type_r[7:0], data_byte};
          end else begin
            val_left_nxt = {val_left_r[7:0], data_byte};
          end
          ahdr_cnt_nxt = ahdr_cnt_r + 2'd1;
          if (ahdr_cnt_nxt == 2'd0) begin
            evt_valid      = 1'b1;
            evt.kind       = smp_pkg::EV_ATTR_START;
            evt.tlv_type   = tlv_type_nxt;
            evt.tlv_length = val_left_nxt;
            // pad value up to a multiple of four bytes
            pad_left_nxt   = 2'd0 - val_left_nxt[1:0];
            if (val_left_nxt != 16'd0) begin
              phase_nxt = smp_pkg::PH_VALUE;
            end else if (pad_left_nxt != 2'd0) begin
              phase_nxt = smp_pkg::PH_PAD;
            end else begin
              phase_nxt = smp_pkg::PH_ATTR_HDR;
            end
          end
        end
        smp_pkg::PH_VALUE: begin
          if (tlv_type_r == user_code) begin
            evt_valid      = 1'b1;
            evt.kind       = smp_pkg::EV_USER_BYTE;
            evt.tlv_type   = tlv_type_r;
            evt.value_byte = data_byte;
            evt.last_value = (val_left_r == 16'd1);
          end
          val_left_nxt = val_left_r - 16'd1;
          if (val_left_nxt == 16'd0) begin
            phase_nxt = (pad_left_r != 2'd0) ? smp_pkg::PH_PAD : smp_pkg::PH_ATTR_HDR;
          end
        end
        default: begin
          pad_left_nxt = pad_left_r - 2'd1;
          if (pad_left_nxt == 2'd0) begin
            phase_nxt = smp_pkg::PH_ATTR_HDR;
          end
        end
      endcase
    end

    evt.msg_type   = type_nxt;
    evt.msg_length = len_nxt;
    evt.txn_high   = txn_nxt[0];
    evt.txn_mid    = txn_nxt[1];
    evt.txn_low    = txn_nxt[2];

    // chunk end after a full header drops back to the reset state
    if (byte_valid && chunk_end && hdr_cnt_nxt == 5'(smp_pkg::HdrBytes)) begin
      hdr_cnt_nxt   = '0;
      phase_nxt     = smp_pkg::PH_HEADER;
      type_nxt      = '0;
      len_nxt       = '0;
      cookie_nxt    = '0;
      txn_nxt[0]    = '0;
      txn_nxt[1]    = '0;
      txn_nxt[2]    = '0;
      ahdr_cnt_nxt  = '0;
      tlv_type_nxt  = '0;
      val_left_nxt  = '0;
      pad_left_nxt  = '0;
      discard_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r   <= '0;
      phase_r     <= smp_pkg::PH_HEADER;
      type_r      <= '0;
      len_r       <= '0;
      cookie_r    <= '0;
      txn_r[0]    <= '0;
      txn_r[1]    <= '0;
      txn_r[2]    <= '0;
      ahdr_cnt_r  <= '0;
      tlv_type_r  <= '0;
      val_left_r  <= '0;
      pad_left_r  <= '0;
      discard_r   <= 1'b0;
    end else begin
      hdr_cnt_r   <= hdr_cnt_nxt;
      phase_r     <= phase_nxt;
      type_r      <= type_nxt;
      len_r       <= len_nxt;
      cookie_r    <= cookie_nxt;
      txn_r[0]    <= txn_nxt[0];
      txn_r[1]    <= txn_nxt[1];
      txn_r[2]    <= txn_nxt[2];
      ahdr_cnt_r  <= ahdr_cnt_nxt;
      tlv_type_r  <= tlv_type_nxt;
      val_left_r  <= val_left_nxt;
      pad_left_r  <= pad_left_nxt;
      discard_r   <= discard_nxt;
    end
  end

endmodule

[hdl/smp_out_buf.sv]
// ----------------------------------------------------------------------------
// smp_out_buf
// Result register with a skid entry behind it.
// ----------------------------------------------------------------------------
module smp_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  smp_pkg::evt_t push_evt,
  output logic          can_accept,
  output logic          out_valid,
  input  logic          out_ready,
  output smp_pkg::evt_t out_evt
);

  logic          main_vld_r, main_vld_nxt;
  logic          skid_vld_r, skid_vld_nxt;
  smp_pkg::evt_t main_r, main_nxt;
  smp_pkg::evt_t skid_r, skid_nxt;
  logic          pop;

  always_comb begin
    pop          = main_vld_r && out_ready;
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (pop) begin
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end else if (push) begin
        main_nxt = push_evt;
      end else begin
        main_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r) begin
        main_nxt     = push_evt;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_evt;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign can_accept = !skid_vld_r;
  assign out_valid  = main_vld_r;
  assign out_evt    = main_r;

endmodule

[hdl/stun_message_parser.sv]
// ----------------------------------------------------------------------------
// stun_message_parser
// Byte-serial STUN message parser with header check and attribute walk.
// ----------------------------------------------------------------------------
// Input channel: one message byte per word (in_data_byte), with in_chunk_end
// marking the last byte of a received chunk. Result channel: one event word
// (header ok, bad cookie, attribute start, username byte) with the message
// header fields, the current attribute and the username byte.
// Config channel: cfg_data sets the attribute type reported as username;
// cfg_ready is always high. Write it only while the block is idle.
// Throughput: one byte per cycle while in_ready is high. A byte is parsed
// in the cycle it is accepted; the result register drives its event out.
// A stalled receiver is absorbed by the result register plus one skid
// entry; in_ready drops only while both hold an event.
// Reset clears the parser to the header phase, empties the result stage
// and restores the username attribute type to 6.
// ----------------------------------------------------------------------------
module stun_message_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_chunk_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_kind,
  output logic [15:0] out_msg_type,
  output logic [15:0] out_msg_length,
  output logic [31:0] out_txn_word_high,
  output logic [31:0] out_txn_word_mid,
  output logic [31:0] out_txn_word_low,
  output logic [15:0] out_attr_type,
  output logic [15:0] out_attr_length,
  output logic [7:0]  out_value_byte,
  output logic        out_last_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0]   user_code_r;
  logic          accept;
  logic          evt_valid;
  smp_pkg::evt_t evt;
  smp_pkg::evt_t out_evt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_code_r <= smp_pkg::UserAttrCodeRst;
    end else if (cfg_valid) begin
      user_code_r <= cfg_data;
    end
  end

  assign accept = in_valid && in_ready;

  smp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (accept),
    .data_byte  (in_data_byte),
    .chunk_end  (in_chunk_end),
    .user_code  (user_code_r),
    .evt_valid  (evt_valid),
    .evt        (evt)
  );

  smp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (evt_valid),
    .push_evt   (evt),
    .can_accept (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_evt    (out_evt)
  );

  assign out_event_kind    = out_evt.kind;
  assign out_msg_type      = out_evt.msg_type;
  assign out_msg_length    = out_evt.msg_length;
  assign out_txn_word_high = out_evt.txn_high;
  assign out_txn_word_mid  = out_evt.txn_mid;
  assign out_txn_word_low  = out_evt.txn_low;
  assign out_attr_type     = out_evt.tlv_type;
  assign out_attr_length   = out_evt.tlv_length;
  assign out_value_byte    = out_evt.value_byte;
  assign out_last_value    = out_evt.last_value;

endmodule

[hdl/smp_checker.sv]
// ----------------------------------------------------------------------------
// smp_checker
// Port-level checks on the result channel of the stun message parser.
// ----------------------------------------------------------------------------
module smp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_event_kind,
  input logic [15:0] out_attr_type,
  input logic [15:0] out_attr_length,
  input logic [7:0]  out_value_byte,
  input logic        out_last_value
);

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_kind)
      && $stable(out_value_byte) && $stable(out_attr_type))
    else $error("result word changed while stalled");

  a_hdr_no_attr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == smp_pkg::EV_HDR_OK
      || out_event_kind == smp_pkg::EV_BAD_COOKIE)
      |-> out_attr_type == 16'd0 && out_attr_length == 16'd0)
    else $error("header event carries attribute fields");

  a_byte_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != smp_pkg::EV_USER_BYTE
      |-> out_value_byte == 8'd0 && !out_last_value)
    else $error("value byte set outside a username event");

  a_user_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == smp_pkg::EV_USER_BYTE |-> out_attr_length == 16'd0)
    else $error("username event carries an attribute length");

endmodule

bind stun_message_parser smp_checker u_smp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_event_kind  (out_event_kind),
  .out_attr_type   (out_attr_type),
  .out_attr_length (out_attr_length),
  .out_value_byte  (out_value_byte),
  .out_last_value  (out_last_value)
);
